[design/mer_pkg.sv]
// ============================================================================
// mer_pkg: shared definitions for the midpoint ellipse rasterizer
// Field widths, register reset values, command codes and the control
// structs that travel between the front, the engine and the emitter.
// ============================================================================
package mer_pkg;

    localparam int AXIS_BITS_DEF = 11;
    localparam int PIX_W         = 14;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_W-1:0] CENTER_X_RST = 12'd900;
    localparam logic [CFG_W-1:0] CENTER_Y_RST = 12'd450;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 1'b1;

    // input item kind
    localparam logic KIND_START = 1'b0;

    // queue head, front to engine
    typedef struct packed {
        logic valid;
        logic start;
    } cmd_ctl_t;

    // traced point, engine to emitter
    typedef struct packed {
        logic valid;
        logic done;
    } pt_ctl_t;

endpackage

[design/mer_front.sv]
// ============================================================================
// mer_front: input acceptance and command queue
// Takes input items, tags each as start or step and holds them in a short
// queue so that the engine and the input side stall independently.
// ============================================================================
module mer_front #(
    parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [AXIS_BITS-1:0]  semi_axis_x,
    input  logic [AXIS_BITS-1:0]  semi_axis_y,
    output mer_pkg::cmd_ctl_t     cmd_ctl,
    output logic [AXIS_BITS-1:0]  cmd_a,
    output logic [AXIS_BITS-1:0]  cmd_b,
    input  logic                  cmd_pop
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
    localparam logic [PTR_W:0]   CNT_ONE = (PTR_W+1)'(1);
    localparam logic [PTR_W:0]   CNT_FULL = (PTR_W+1)'(DEPTH);

    logic                 q_start_reg [DEPTH];
    logic [AXIS_BITS-1:0] q_a_reg     [DEPTH];
    logic [AXIS_BITS-1:0] q_b_reg     [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             push;
    logic             pop;

    assign in_ready = (count_reg != CNT_FULL);
    assign push     = in_valid && in_ready;
    assign pop      = cmd_pop && (count_reg != '0);

    assign cmd_ctl.valid = (count_reg != '0);
    assign cmd_ctl.start = q_start_reg[rd_ptr_reg];
    assign cmd_a         = q_a_reg[rd_ptr_reg];
    assign cmd_b         = q_b_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_ONE : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_ONE;
            2'b01:   count_next = count_reg - CNT_ONE;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_start_reg[wr_ptr_reg] <= (kind == mer_pkg::KIND_START);
            q_a_reg[wr_ptr_reg]     <= semi_axis_x;
            q_b_reg[wr_ptr_reg]     <= semi_axis_y;
        end
    end

endmodule

[design/mer_core.sv]
// ============================================================================
// mer_core: midpoint ellipse stepping engine
// Sets up the squared semi-axes and cross products for a start command,
// then advances one point per step command with running products, so each
// step is adds and compares only.
// ============================================================================
module mer_core #(
    parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mer_pkg::cmd_ctl_t     cmd_ctl,
    input  logic [AXIS_BITS-1:0]  cmd_a,
    input  logic [AXIS_BITS-1:0]  cmd_b,
    output logic                  cmd_pop,
    output mer_pkg::pt_ctl_t      pt_ctl,
    output logic [AXIS_BITS-1:0]  pt_x,
    output logic [AXIS_BITS-1:0]  pt_y,
    input  logic                  pt_ready
);

    localparam int SQ_W  = 2 * AXIS_BITS;
    localparam int PRD_W = 3 * AXIS_BITS;
    localparam int T_W   = 3 * AXIS_BITS + 2;
    localparam int XY_W  = AXIS_BITS + 2;
    localparam int ERR_W = 3 * AXIS_BITS + 7;

    localparam logic signed [XY_W-1:0] XY_ONE = XY_W'(1);

    localparam logic [1:0] PH_RUN  = 2'd0;
    localparam logic [1:0] PH_SQ   = 2'd1;
    localparam logic [1:0] PH_PROD = 2'd2;
    localparam logic [1:0] PH_INIT = 2'd3;

    localparam logic [1:0] RGN_IDLE = 2'd0;
    localparam logic [1:0] RGN_ONE  = 2'd1;
    localparam logic [1:0] RGN_TWO  = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [1:0] region_reg;
    logic [1:0] region_next;

    // setup values, fixed for one ellipse
    logic [AXIS_BITS-1:0]    a_reg;
    logic [AXIS_BITS-1:0]    b_reg;
    logic [SQ_W-1:0]         asq_reg;
    logic [SQ_W-1:0]         bsq_reg;
    logic [PRD_W-1:0]        a2b_reg;
    logic [PRD_W-1:0]        ab2_reg;
    logic signed [ERR_W-1:0] c6a_reg;
    logic signed [ERR_W-1:0] c6b_reg;
    logic signed [ERR_W-1:0] e2i_reg;

    // running trace state: t1 = b^2 * x, t2 = a^2 * y
    logic signed [XY_W-1:0]  x_reg;
    logic signed [XY_W-1:0]  x_next;
    logic signed [XY_W-1:0]  y_reg;
    logic signed [XY_W-1:0]  y_next;
    logic signed [T_W-1:0]   t1_reg;
    logic signed [T_W-1:0]   t1_next;
    logic signed [T_W-1:0]   t2_reg;
    logic signed [T_W-1:0]   t2_next;
    logic signed [ERR_W-1:0] e_reg;
    logic signed [ERR_W-1:0] e_next;

    logic signed [XY_W-1:0]  a_xy;
    logic signed [XY_W-1:0]  b_xy;
    logic signed [ERR_W-1:0] asq_e;
    logic signed [ERR_W-1:0] bsq_e;
    logic signed [ERR_W-1:0] a2b_e;
    logic signed [ERR_W-1:0] ab2_e;
    logic signed [T_W-1:0]   asq_t;
    logic signed [T_W-1:0]   bsq_t;
    logic signed [T_W-1:0]   a2b_t;
    logic signed [T_W-1:0]   ab2_t;

    logic start_go;
    logic step_go;
    logic r1_ok;
    logic r1_end;
    logic r2_ok;
    logic r1_ge;
    logic r2_ge;

    logic signed [ERR_W-1:0] e1_step;
    logic signed [ERR_W-1:0] e1_new;
    logic signed [XY_W-1:0]  x1_new;
    logic signed [XY_W-1:0]  y1_new;
    logic signed [T_W-1:0]   t1_1_new;
    logic signed [T_W-1:0]   t2_1_new;

    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic signed [T_W-1:0]   t1s;
    logic signed [T_W-1:0]   t2s;
    logic signed [ERR_W-1:0] es;
    logic signed [ERR_W-1:0] e2_step;
    logic signed [ERR_W-1:0] e2_new;
    logic signed [XY_W-1:0]  x2_new;
    logic signed [XY_W-1:0]  y2_new;
    logic signed [T_W-1:0]   t1_2_new;
    logic signed [T_W-1:0]   t2_2_new;

    assign a_xy  = $signed(XY_W'(a_reg));
    assign b_xy  = $signed(XY_W'(b_reg));
    assign asq_e = $signed(ERR_W'(asq_reg));
    assign bsq_e = $signed(ERR_W'(bsq_reg));
    assign a2b_e = $signed(ERR_W'(a2b_reg));
    assign ab2_e = $signed(ERR_W'(ab2_reg));
    assign asq_t = $signed(T_W'(asq_reg));
    assign bsq_t = $signed(T_W'(bsq_reg));
    assign a2b_t = $signed(T_W'(a2b_reg));
    assign ab2_t = $signed(T_W'(ab2_reg));

    assign start_go = (phase_reg == PH_RUN) && cmd_ctl.valid && cmd_ctl.start;
    assign step_go  = (phase_reg == PH_RUN) && cmd_ctl.valid && !cmd_ctl.start && pt_ready;
    assign cmd_pop  = start_go || step_go;

    // region one: x advances, y may drop
    assign r1_ok  = (region_reg == RGN_ONE) && (x_reg <= a_xy) && !y_reg[XY_W-1]
                    && (t1_reg <= t2_reg);
    assign r1_end = (region_reg == RGN_ONE) && !r1_ok;
    assign r1_ge  = !e_reg[ERR_W-1];

    assign e1_step  = r1_ge ? (asq_e <<< 2) - (ERR_W'(t2_reg) <<< 2) : '0;
    assign e1_new   = e_reg + e1_step + (ERR_W'(t1_reg) <<< 2) + c6b_reg;
    assign x1_new   = x_reg + XY_ONE;
    assign y1_new   = r1_ge ? y_reg - XY_ONE : y_reg;
    assign t1_1_new = t1_reg + bsq_t;
    assign t2_1_new = r1_ge ? t2_reg - asq_t : t2_reg;

    // region two: when region one runs out, start from (a, 0) in the same step
    assign xs  = r1_end ? a_xy : x_reg;
    assign ys  = r1_end ? '0 : y_reg;
    assign t1s = r1_end ? ab2_t : t1_reg;
    assign t2s = r1_end ? '0 : t2_reg;
    assign es  = r1_end ? e2i_reg : e_reg;

    // the start point of region two always passes its own test
    assign r2_ok = r1_end || ((region_reg == RGN_TWO) && (y_reg <= b_xy)
                    && !x_reg[XY_W-1] && (t2_reg <= t1_reg));
    assign r2_ge = !es[ERR_W-1];

    assign e2_step  = r2_ge ? (bsq_e <<< 2) - (ERR_W'(t1s) <<< 2) : '0;
    assign e2_new   = es + e2_step + (ERR_W'(t2s) <<< 2) + c6a_reg;
    assign x2_new   = r2_ge ? xs - XY_ONE : xs;
    assign y2_new   = ys + XY_ONE;
    assign t1_2_new = r2_ge ? t1s - bsq_t : t1s;
    assign t2_2_new = t2s + asq_t;

    assign pt_ctl.valid = step_go;
    assign pt_ctl.done  = !r1_ok && !r2_ok;
    assign pt_x         = r1_ok ? x_reg[AXIS_BITS-1:0] : xs[AXIS_BITS-1:0];
    assign pt_y         = r1_ok ? y_reg[AXIS_BITS-1:0] : ys[AXIS_BITS-1:0];

    always_comb
    begin
        unique case (phase_reg)
            PH_RUN:  phase_next = start_go ? PH_SQ : PH_RUN;
            PH_SQ:   phase_next = PH_PROD;
            PH_PROD: phase_next = PH_INIT;
            PH_INIT: phase_next = PH_RUN;
        endcase
    end

    always_comb
    begin
        region_next = region_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        e_next      = e_reg;
        priority if (phase_reg == PH_INIT)
        begin
            region_next = RGN_ONE;
            x_next      = '0;
            y_next      = b_xy;
            t1_next     = '0;
            t2_next     = a2b_t;
            e_next      = (bsq_e <<< 1) + asq_e - (a2b_e <<< 1);
        end
        else if (step_go && r1_ok)
        begin
            x_next  = x1_new;
            y_next  = y1_new;
            t1_next = t1_1_new;
            t2_next = t2_1_new;
            e_next  = e1_new;
        end
        else if (step_go && r2_ok)
        begin
            region_next = RGN_TWO;
            x_next      = x2_new;
            y_next      = y2_new;
            t1_next     = t1_2_new;
            t2_next     = t2_2_new;
            e_next      = e2_new;
        end
        else if (step_go)
        begin
            region_next = RGN_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RUN;
            region_reg <= RGN_IDLE;
        end
        else
        begin
            phase_reg  <= phase_next;
            region_reg <= region_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_go)
        begin
            a_reg <= cmd_a;
            b_reg <= cmd_b;
        end
        if (phase_reg == PH_SQ)
        begin
            asq_reg <= SQ_W'(a_reg) * SQ_W'(a_reg);
            bsq_reg <= SQ_W'(b_reg) * SQ_W'(b_reg);
        end
        if (phase_reg == PH_PROD)
        begin
            a2b_reg <= PRD_W'(asq_reg) * PRD_W'(b_reg);
            ab2_reg <= PRD_W'(bsq_reg) * PRD_W'(a_reg);
            c6a_reg <= (asq_e <<< 2) + (asq_e <<< 1);
            c6b_reg <= (bsq_e <<< 2) + (bsq_e <<< 1);
        end
        if (phase_reg == PH_INIT)
        begin
            e2i_reg <= (asq_e <<< 1) + bsq_e - (ab2_e <<< 1);
        end
        x_reg  <= x_next;
        y_reg  <= y_next;
        t1_reg <= t1_next;
        t2_reg <= t2_next;
        e_reg  <= e_next;
    end

endmodule

[design/mer_emit.sv]
// ============================================================================
// mer_emit: mirror pixel emitter and center registers
// Holds one traced point, forms the four mirrored screen pixels around the
// center and hands them out one per transfer, or one done result.
// ============================================================================
module mer_emit #(
    parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mer_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mer_pkg::CFG_W-1:0]          cfg_data,
    input  mer_pkg::pt_ctl_t                   pt_ctl,
    input  logic [AXIS_BITS-1:0]               pt_x,
    input  logic [AXIS_BITS-1:0]               pt_y,
    output logic                               pt_ready,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mer_pkg::PIX_W-1:0]   pixel_x,
    output logic signed [mer_pkg::PIX_W-1:0]   pixel_y,
    output logic                               pixel_valid,
    output logic                               last_of_step,
    output logic                               done_res
);

    localparam int PW = mer_pkg::PIX_W;
    localparam logic [1:0] IDX_LAST = 2'd3;
    localparam logic [1:0] IDX_ONE  = 2'd1;

    logic [mer_pkg::CFG_W-1:0] center_x_reg;
    logic [mer_pkg::CFG_W-1:0] center_y_reg;

    logic          held_reg;
    logic          held_next;
    logic [1:0]    idx_reg;
    logic [1:0]    idx_next;
    logic          done_reg;
    logic [PW-1:0] xpos_reg;
    logic [PW-1:0] xneg_reg;
    logic [PW-1:0] ypos_reg;
    logic [PW-1:0] yneg_reg;

    logic [PW-1:0] cx;
    logic [PW-1:0] cy;
    logic [PW-1:0] x_off;
    logic [PW-1:0] y_off;
    logic          last_now;
    logic          fin;

    assign cx    = PW'(center_x_reg);
    assign cy    = PW'(center_y_reg);
    assign x_off = PW'(pt_x);
    assign y_off = PW'(pt_y);

    assign last_now = done_reg || (idx_reg == IDX_LAST);
    assign fin      = held_reg && out_ready && last_now;
    assign pt_ready = !held_reg || fin;

    // order: (+x,+y), (-x,+y), (+x,-y), (-x,-y)
    assign out_valid    = held_reg;
    assign pixel_x      = $signed(idx_reg[0] ? xneg_reg : xpos_reg);
    assign pixel_y      = $signed(idx_reg[1] ? yneg_reg : ypos_reg);
    assign pixel_valid  = !done_reg;
    assign last_of_step = last_now;
    assign done_res     = done_reg;

    always_comb
    begin
        held_next = held_reg;
        idx_next  = idx_reg;
        priority if (pt_ctl.valid)
        begin
            held_next = 1'b1;
            idx_next  = '0;
        end
        else if (fin)
        begin
            held_next = 1'b0;
        end
        else if (held_reg && out_ready)
        begin
            idx_next = idx_reg + IDX_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= mer_pkg::CENTER_X_RST;
            center_y_reg <= mer_pkg::CENTER_Y_RST;
            held_reg     <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            held_reg <= held_next;
            idx_reg  <= idx_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    mer_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                    mer_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                endcase
            end
        end
    end

    // a done result carries zero coordinates
    always_ff @(posedge clk)
    begin
        if (pt_ctl.valid)
        begin
            done_reg <= pt_ctl.done;
            xpos_reg <= pt_ctl.done ? '0 : cx + x_off;
            xneg_reg <= pt_ctl.done ? '0 : cx - x_off;
            ypos_reg <= pt_ctl.done ? '0 : cy + y_off;
            yneg_reg <= pt_ctl.done ? '0 : cy - y_off;
        end
    end

endmodule

[design/midpoint_ellipse_rasterizer.sv]
// ============================================================================
// midpoint_ellipse_rasterizer: axis-aligned midpoint ellipse pixel generator
// Traces an ellipse with semi-axes a and b in two regions and emits the four
// mirrored pixels of each traced point around a programmable center.
// ============================================================================

// A start item loads a and b and gives no result; each step item gives four
// pixels (last one marked) or, once the ellipse is traced, one done result.
// The output carries one pixel per transfer, so a step that traces a point
// occupies the output for four transfers and a step past the end for one; with
// out_ready held high and steps queued, the block sustains one pixel per cycle.
// A start passes the stepping engine through latch, square, cross products and
// error setup, and overlaps the drain of earlier pixels through the 2-entry
// input queue; a start between two traced steps still leaves the output idle
// between their pixels. Each step is adds and compares on running products.
// Center registers should be written only while no work is pending.
module midpoint_ellipse_rasterizer #(
    parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mer_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mer_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic [AXIS_BITS-1:0]               semi_axis_x,
    input  logic [AXIS_BITS-1:0]               semi_axis_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mer_pkg::PIX_W-1:0]   pixel_x,
    output logic signed [mer_pkg::PIX_W-1:0]   pixel_y,
    output logic                               pixel_valid,
    output logic                               last_of_step,
    output logic                               done_res
);

    mer_pkg::cmd_ctl_t    cmd_ctl;
    logic [AXIS_BITS-1:0] cmd_a;
    logic [AXIS_BITS-1:0] cmd_b;
    logic                 cmd_pop;
    mer_pkg::pt_ctl_t     pt_ctl;
    logic [AXIS_BITS-1:0] pt_x;
    logic [AXIS_BITS-1:0] pt_y;
    logic                 pt_ready;

    mer_front #(
        .AXIS_BITS (AXIS_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .semi_axis_x (semi_axis_x),
        .semi_axis_y (semi_axis_y),
        .cmd_ctl     (cmd_ctl),
        .cmd_a       (cmd_a),
        .cmd_b       (cmd_b),
        .cmd_pop     (cmd_pop)
    );

    mer_core #(
        .AXIS_BITS (AXIS_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_ctl  (cmd_ctl),
        .cmd_a    (cmd_a),
        .cmd_b    (cmd_b),
        .cmd_pop  (cmd_pop),
        .pt_ctl   (pt_ctl),
        .pt_x     (pt_x),
        .pt_y     (pt_y),
        .pt_ready (pt_ready)
    );

    mer_emit #(
        .AXIS_BITS (AXIS_BITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pt_ctl       (pt_ctl),
        .pt_x         (pt_x),
        .pt_y         (pt_y),
        .pt_ready     (pt_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_valid  (pixel_valid),
        .last_of_step (last_of_step),
        .done_res     (done_res)
    );

`ifndef NO_ASSERTIONS
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> last_of_step && !pixel_valid)
        else $error("done result not marked last or carries a pixel");

    a_pt_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        pt_ctl.valid |-> pt_ready)
        else $error("engine handed a point to a busy emitter");

    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_step |=> out_valid)
        else $error("pixel burst dropped before its last transfer");

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> cmd_ctl.valid)
        else $error("queue reports full with no command at its head");
`endif

endmodule

[tb/midpoint_ellipse_rasterizer_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// midpoint_ellipse_rasterizer_tb: self-checking bench for the ellipse tracer
// Traces ellipses from start and step transfers with random input gaps and
// output stalls. A built-in midpoint predictor checks every pixel transfer.
// ============================================================================
module midpoint_ellipse_rasterizer_tb;

    localparam int AXIS_W        = mer_pkg::AXIS_BITS_DEF;
    localparam int PIX_W         = mer_pkg::PIX_W;
    localparam int CFG_W         = mer_pkg::CFG_W;
    localparam logic KIND_STEP   = ~mer_pkg::KIND_START;
    localparam int ITEM_TARGET   = 410;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    typedef enum logic [1:0] {
        TRACE_IDLE,
        TRACE_REGION_ONE,
        TRACE_REGION_TWO
    } trace_region_t;

    typedef struct {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic                    pv;
        logic                    last;
        logic                    done;
    } pixel_rec_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [mer_pkg::CFG_IDX_W-1:0]  cfg_index = mer_pkg::CFG_CENTER_X;
    logic [CFG_W-1:0]               cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           kind = mer_pkg::KIND_START;
    logic [AXIS_W-1:0]              semi_axis_x = '0;
    logic [AXIS_W-1:0]              semi_axis_y = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [PIX_W-1:0]        pixel_x;
    logic signed [PIX_W-1:0]        pixel_y;
    logic                           pixel_valid;
    logic                           last_of_step;
    logic                           done_res;

    // predictor state
    logic [CFG_W-1:0] pred_center_x = mer_pkg::CENTER_X_RST;
    logic [CFG_W-1:0] pred_center_y = mer_pkg::CENTER_Y_RST;
    trace_region_t    trace_region = TRACE_IDLE;
    longint           pos_x = 0;
    longint           pos_y = 0;
    longint           midpoint_err = 0;
    longint           axis_a = 0;
    longint           axis_b = 0;
    longint           sq_a = 0;
    longint           sq_b = 0;

    pixel_rec_t expected_pixels[$];

    bit quiet_in = 1'b0;
    bit quiet_out = 1'b0;
    int items_sent = 0;
    int starts_sent = 0;
    int results_checked = 0;
    int pixels_checked = 0;
    int done_checked = 0;
    int centers_programmed = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    midpoint_ellipse_rasterizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .semi_axis_x  (semi_axis_x),
        .semi_axis_y  (semi_axis_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_valid  (pixel_valid),
        .last_of_step (last_of_step),
        .done_res     (done_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_pixels.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Midpoint predictor
    // ------------------------------------------------------------------
    function automatic void emit_quad(longint x, longint y);
        pixel_rec_t rec;
        longint     cx;
        longint     cy;
        cx = longint'(pred_center_x);
        cy = longint'(pred_center_y);
        for (int k = 0; k < 4; k++)
        begin
            rec.px   = PIX_W'(cx + (((k % 2) == 1) ? -x : x));
            rec.py   = PIX_W'(cy + ((k >= 2) ? -y : y));
            rec.pv   = 1'b1;
            rec.last = (k == 3);
            rec.done = 1'b0;
            expected_pixels.push_back(rec);
        end
    endfunction

    // Returns 1 when the item yields the done result.
    function automatic bit predict_ellipse_step(logic k, logic [AXIS_W-1:0] a,
                                                logic [AXIS_W-1:0] b);
        pixel_rec_t fin;
        if (k == mer_pkg::KIND_START)
        begin
            axis_a       = longint'(a);
            axis_b       = longint'(b);
            sq_a         = axis_a * axis_a;
            sq_b         = axis_b * axis_b;
            pos_x        = 0;
            pos_y        = axis_b;
            midpoint_err = 2 * sq_b + sq_a * (1 - 2 * axis_b);
            trace_region = TRACE_REGION_ONE;
            return 1'b0;
        end
        if (trace_region == TRACE_REGION_ONE)
        begin
            if (pos_x <= axis_a && pos_y >= 0 && sq_b * pos_x <= sq_a * pos_y)
            begin
                emit_quad(pos_x, pos_y);
                if (midpoint_err >= 0)
                begin
                    midpoint_err += 4 * sq_a * (1 - pos_y);
                    pos_y -= 1;
                end
                midpoint_err += 2 * sq_b * (2 * pos_x + 3);
                pos_x += 1;
                return 1'b0;
            end
            // region one exhausted: set up region two and trace it this step
            pos_y        = 0;
            pos_x        = axis_a;
            midpoint_err = 2 * sq_a + sq_b * (1 - 2 * axis_a);
            trace_region = TRACE_REGION_TWO;
        end
        if (trace_region == TRACE_REGION_TWO)
        begin
            if (pos_y <= axis_b && pos_x >= 0 && sq_a * pos_y <= sq_b * pos_x)
            begin
                emit_quad(pos_x, pos_y);
                if (midpoint_err >= 0)
                begin
                    midpoint_err += 4 * sq_b * (1 - pos_x);
                    pos_x -= 1;
                end
                midpoint_err += 2 * sq_a * (2 * pos_y + 3);
                pos_y += 1;
                return 1'b0;
            end
            trace_region = TRACE_IDLE;
        end
        fin.px   = '0;
        fin.py   = '0;
        fin.pv   = 1'b0;
        fin.last = 1'b1;
        fin.done = 1'b1;
        expected_pixels.push_back(fin);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_item(input logic k, input logic [AXIS_W-1:0] a,
                             input logic [AXIS_W-1:0] b, output bit finished);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        semi_axis_x <= a;
        semi_axis_y <= b;
        do
            @(posedge clk);
        while (!in_ready);
        finished = predict_ellipse_step(k, a, b);
        items_sent++;
        if (k == mer_pkg::KIND_START)
            starts_sent++;
    endtask

    // Drop valid, wait out every pending result, then let the engine settle.
    task automatic wait_for_drain(input int settle);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic program_center(input logic [CFG_W-1:0] cx,
                                  input logic [CFG_W-1:0] cy);
        cfg_write <= 1'b1;
        cfg_index <= mer_pkg::CFG_CENTER_X;
        cfg_data  <= cx;
        @(posedge clk);
        cfg_index <= mer_pkg::CFG_CENTER_Y;
        cfg_data  <= cy;
        @(posedge clk);
        cfg_write     <= 1'b0;
        pred_center_x = cx;
        pred_center_y = cy;
        centers_programmed++;
    endtask

    // Start an ellipse and step it until done or max_steps; if done, step past the end extra times.
    task automatic trace_ellipse(input logic [AXIS_W-1:0] a, input logic [AXIS_W-1:0] b,
                                 input int max_steps, input int extra);
        bit finished;
        int taken;
        send_item(mer_pkg::KIND_START, a, b, finished);
        taken = 0;
        while (!finished && taken < max_steps)
        begin
            send_item(KIND_STEP, AXIS_W'($urandom), AXIS_W'($urandom), finished);
            taken++;
        end
        if (finished)
            repeat (extra) send_item(KIND_STEP, AXIS_W'($urandom), AXIS_W'($urandom),
                                     finished);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = quiet_out ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Sample each transfer at the edge, compare at the following falling edge.
    initial
    begin
        pixel_rec_t got;
        pixel_rec_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.px   = pixel_x;
                got.py   = pixel_y;
                got.pv   = pixel_valid;
                got.last = last_of_step;
                got.done = done_res;
                @(negedge clk);
                results_checked++;
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("Unexpected result: x=%0d y=%0d pv=%b last=%b done=%b",
                                 got.px, got.py, got.pv, got.last, got.done);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.done)
                        done_checked++;
                    else
                        pixels_checked++;
                    if (got.px !== want.px || got.py !== want.py || got.pv !== want.pv ||
                        got.last !== want.last || got.done !== want.done)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                        begin
                            $display("Mismatch at result %0d: expected x=%0d y=%0d pv=%b last=%b done=%b",
                                     results_checked, want.px, want.py, want.pv,
                                     want.last, want.done);
                            $display("    got x=%0d y=%0d pv=%b last=%b done=%b",
                                     got.px, got.py, got.pv, got.last, got.done);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_step_before_start();
        bit finished;
        send_item(KIND_STEP, '1, '0, finished);
    endtask

    task automatic test_small_ellipse();
        trace_ellipse(AXIS_W'(3), AXIS_W'(2), 1000, 1);
    endtask

    // Flat and thin ellipses reach the far pixel extremes at the corner centers.
    task automatic test_axis_extremes();
        wait_for_drain(SETTLE_CYCLES);
        program_center('0, '0);
        trace_ellipse('1, '0, 1000, 0);
        wait_for_drain(SETTLE_CYCLES);
        program_center('1, '1);
        trace_ellipse('0, '1, 1000, 0);
        trace_ellipse('0, '0, 1000, 0);
    endtask

    task automatic test_random_traces();
        int since_cfg;
        int choice;
        int max_steps;
        bit finished;
        logic [CFG_W-1:0] cx;
        logic [CFG_W-1:0] cy;
        logic [AXIS_W-1:0] a;
        logic [AXIS_W-1:0] b;
        since_cfg = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (since_cfg > 70)
            begin
                wait_for_drain(SETTLE_CYCLES);
                choice = $urandom_range(0, 3);
                cx = (choice == 0) ? '0 : (choice == 1) ? '1 : CFG_W'($urandom);
                choice = $urandom_range(0, 3);
                cy = (choice == 0) ? '0 : (choice == 1) ? '1 : CFG_W'($urandom);
                program_center(cx, cy);
                since_cfg = 0;
            end
            since_cfg -= items_sent;
            quiet_in  = ($urandom_range(0, 5) == 0);
            quiet_out = quiet_in;
            choice = $urandom_range(0, 9);
            if (choice < 7)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    // large ellipse: trace only a few points, then abandon
                    a = AXIS_W'($urandom);
                    b = AXIS_W'($urandom);
                    max_steps = $urandom_range(1, 6);
                end
                else
                begin
                    a = AXIS_W'($urandom_range(0, 12));
                    b = AXIS_W'($urandom_range(0, 12));
                    max_steps = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 100000;
                end
                trace_ellipse(a, b, max_steps, $urandom_range(0, 2));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_item(logic'($urandom_range(0, 1)), AXIS_W'($urandom),
                              AXIS_W'($urandom), finished);
            end
            since_cfg += items_sent;
        end
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_step_before_start();
        test_small_ellipse();
        test_axis_extremes();
        test_random_traces();
        wait_for_drain(SETTLE_CYCLES);
        $display("Ran %0d items (%0d starts) under %0d center settings plus the reset one.",
                 items_sent, starts_sent, centers_programmed);
        $display("Checked %0d results: %0d pixels and %0d end-of-trace markers, %0d bad.",
                 results_checked, pixels_checked, done_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
design/mer_pkg.sv
design/mer_front.sv
design/mer_core.sv
design/mer_emit.sv
design/midpoint_ellipse_rasterizer.sv
tb/midpoint_ellipse_rasterizer_tb.sv
